// ----- hdl/differential_rms_meter_assert.svh -----
// ----------------------------------------------------------------------------
// differential_rms_meter_assert.svh
// Assertion macros shared by the RMS meter checker.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_RMS_METER_ASSERT_SVH
`define DIFFERENTIAL_RMS_METER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DRM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/drm_pkg.sv -----
// ----------------------------------------------------------------------------
// drm_pkg
// Payload types, register codes and fixed constants of the RMS meter.
// ----------------------------------------------------------------------------
package drm_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int THRESHOLD_W  = 16;
  localparam int REFERENCE_W  = 8;
  localparam int RATIO_W      = 24;
  localparam int LEVEL_W      = 32;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 16;

  // Q.24 scale of the mean square, Q.12 scale of the level numerator,
  // and the factor 16 folded into the calibration divisor.
  localparam int FRAC_SHIFT   = 24;
  localparam int LEVEL_SHIFT  = 12;
  localparam int REF_SHIFT    = 4;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'd3277;
  localparam logic [REFERENCE_W-1:0] REFERENCE_RESET = 8'd5;
  localparam logic [RATIO_W-1:0]     RATIO_ONE       = 24'd256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ZERO_THRESHOLD = 1'd0,
    REG_CAL_REFERENCE  = 1'd1
  } drm_reg_e;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_MEAN,
    ENG_ROOT,
    ENG_LOAD,
    ENG_DIV,
    ENG_DONE
  } drm_state_t;

  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] sample_pos;
    logic [SAMPLE_W-1:0] sample_neg;
    logic                last_sample;
  } drm_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms_value;
    logic [RATIO_W-1:0] ratio_value;
    logic               is_calibration;
  } drm_out_t;

  typedef struct packed {
    logic go;
    logic calib;
  } drm_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } drm_status_t;

endpackage

// ----- hdl/differential_rms_meter.sv -----
// ----------------------------------------------------------------------------
// differential_rms_meter
// Windowed RMS of differential sample pairs with gain calibration.
// ----------------------------------------------------------------------------
// Unless a window close stalls the input, a sample pair that does not close a
// window is taken as soon as it is valid, and the next pair may follow at once.
// A pair marked last closes the window; the input then stalls while the close
// engine works out the mean, the root and then a quotient (the level in measure
// mode, the gain ratio in calibrate mode), and it stays stalled at the end until
// the output register can take the result, so longer if the previous result is
// still held there. The close engine has a single subtract/compare unit, which
// yields one bit of the mean, of the root or of the scaled quotient per cycle.
module differential_rms_meter #(
  parameter int SAMPLE_BITS = 12,
  parameter int WINDOW_MAX  = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  drm_pkg::drm_in_t                sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output drm_pkg::drm_out_t               result,
  input  logic                            write_enable,
  input  logic [drm_pkg::CFG_INDEX_W-1:0] reg_index,
  input  logic [drm_pkg::CFG_DATA_W-1:0]  write_data
);
  import drm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = CNT_W + 2 * SAMPLE_BITS;

  logic [THRESHOLD_W-1:0]     zero_threshold;
  logic [REFERENCE_W-1:0]     cal_reference;
  logic [SUM_W-1:0]           square_sum;
  logic [CNT_W-1:0]           pair_count;
  logic                       close_pending;
  logic                       close_calib;

  logic [SAMPLE_BITS-1:0]     pos;
  logic [SAMPLE_BITS-1:0]     neg;
  logic [SAMPLE_BITS-1:0]     mag;
  logic [2*SAMPLE_BITS-1:0]   square;
  logic                       in_xfer;
  logic                       out_free;

  drm_req_t                   solver_req;
  drm_status_t                solver_status;
  drm_out_t                   solver_result;

  assign sample_stall = close_pending | solver_status.busy;
  assign in_xfer      = sample_valid & ~sample_stall;
  assign out_free     = ~result_valid | ~result_stall;

  assign pos    = SAMPLE_BITS'(sample.sample_pos);
  assign neg    = SAMPLE_BITS'(sample.sample_neg);
  assign mag    = (pos >= neg) ? pos - neg : neg - pos;
  assign square = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);

  assign solver_req.go    = close_pending;
  assign solver_req.calib = close_calib;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_threshold <= THRESHOLD_RESET;
      cal_reference  <= REFERENCE_RESET;
    end else if (write_enable) begin
      unique case (drm_reg_e'(reg_index))
        REG_ZERO_THRESHOLD: zero_threshold <= write_data[THRESHOLD_W-1:0];
        REG_CAL_REFERENCE:  cal_reference  <= write_data[REFERENCE_W-1:0];
        default:            zero_threshold <= zero_threshold;
      endcase
    end
  end

  // Accumulate until the window is full; the engine takes the totals
  // the cycle after the last pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      pair_count    <= '0;
      close_pending <= 1'b0;
      close_calib   <= 1'b0;
    end else if (close_pending) begin
      square_sum    <= '0;
      pair_count    <= '0;
      close_pending <= 1'b0;
    end else if (in_xfer) begin
      if (pair_count < CNT_W'(WINDOW_MAX)) begin
        square_sum <= square_sum + SUM_W'(square);
        pair_count <= pair_count + CNT_W'(1);
      end
      if (sample.last_sample) begin
        close_pending <= 1'b1;
        close_calib   <= sample.command;
      end
    end
  end

  drm_solver #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WINDOW_MAX  (WINDOW_MAX)
  ) u_solver (
    .clk            (clk),
    .rst            (rst),
    .req            (solver_req),
    .window_sum     (square_sum),
    .window_count   (pair_count),
    .zero_threshold (zero_threshold),
    .cal_reference  (cal_reference),
    .out_free       (out_free),
    .status         (solver_status),
    .result         (solver_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (solver_status.done && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (solver_status.done && out_free) begin
      result <= solver_result;
    end
  end

endmodule

// ----- hdl/drm_solver.sv -----
// ----------------------------------------------------------------------------
// drm_solver
// Window close engine: mean, root and scaling on one shared subtract unit.
// ----------------------------------------------------------------------------
module drm_solver #(
  parameter int  SAMPLE_BITS = 12,
  parameter int  WINDOW_MAX  = 1024,
  localparam int CNT_W       = $clog2(WINDOW_MAX + 1),
  localparam int SUM_W       = CNT_W + 2 * SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  drm_pkg::drm_req_t               req,
  input  logic [SUM_W-1:0]                window_sum,
  input  logic [CNT_W-1:0]                window_count,
  input  logic [drm_pkg::THRESHOLD_W-1:0] zero_threshold,
  input  logic [drm_pkg::REFERENCE_W-1:0] cal_reference,
  input  logic                            out_free,
  output drm_pkg::drm_status_t            status,
  output drm_pkg::drm_out_t               result
);
  import drm_pkg::*;

  localparam int MEAN_W = 2 * SAMPLE_BITS + FRAC_SHIFT;
  localparam int ROOT_W = MEAN_W / 2;
  localparam int QUO_W  = ROOT_W + LEVEL_SHIFT;
  localparam int WORK_W = SUM_W + FRAC_SHIFT;
  localparam int REM_W  = (ROOT_W + 1 > RATIO_W) ? ROOT_W + 1 : RATIO_W;
  localparam int PART_W = REM_W + 2;
  localparam int ITER_W = $clog2(WORK_W + 1);
  localparam int ALIGN  = WORK_W - ROOT_W;

  drm_state_t          state, state_next;
  logic [RATIO_W-1:0]  gain_ratio;
  logic [WORK_W-1:0]   work;
  logic [REM_W-1:0]    rem;
  logic [ROOT_W-1:0]   root;
  logic [CNT_W-1:0]    count;
  logic [ITER_W-1:0]   iter;
  logic                calib;

  logic [PART_W-1:0]   partial;
  logic [PART_W-1:0]   trial;
  logic [PART_W-1:0]   diff;
  logic                ge;
  logic [REM_W-1:0]    rem_step;
  logic                last_iter;

  logic                level_over;
  logic                ratio_over;
  logic [LEVEL_W-1:0]  level;
  logic [RATIO_W-1:0]  ratio_new;

  assign last_iter = (iter == ITER_W'(1));

  // Shared restoring step: shift bits into the partial remainder,
  // compare with the trial value, subtract when it fits.
  always_comb begin
    partial = '0;
    trial   = '0;
    unique case (state)
      ENG_MEAN: begin
        partial = PART_W'({rem, work[WORK_W-1]});
        trial   = PART_W'(count);
      end
      ENG_ROOT: begin
        partial = {rem, work[MEAN_W-1 -: 2]};
        trial   = PART_W'({root, 2'b01});
      end
      ENG_DIV: begin
        partial = PART_W'({rem, work[WORK_W-1]});
        trial   = calib ? PART_W'({cal_reference, {REF_SHIFT{1'b0}}})
                        : PART_W'(gain_ratio);
      end
      default: begin
        partial = '0;
        trial   = '0;
      end
    endcase
    ge       = (partial >= trial);
    diff     = partial - trial;
    rem_step = ge ? REM_W'(diff) : REM_W'(partial);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE: if (req.go)     state_next = ENG_MEAN;
      ENG_MEAN: if (last_iter)  state_next = ENG_ROOT;
      ENG_ROOT: if (last_iter)  state_next = ENG_LOAD;
      ENG_LOAD:                 state_next = ENG_DIV;
      ENG_DIV:  if (last_iter)  state_next = ENG_DONE;
      ENG_DONE: if (out_free)   state_next = ENG_IDLE;
      default:                  state_next = ENG_IDLE;
    endcase
  end

  always_comb begin
    level_over = |work[WORK_W-1:LEVEL_W];
    ratio_over = |work[WORK_W-1:RATIO_W];

    level = (gain_ratio == '0 || level_over) ? '1 : work[LEVEL_W-1:0];
    if (level < LEVEL_W'(zero_threshold)) begin
      level = '0;
    end
    ratio_new = (cal_reference == '0 || ratio_over) ? '1 : work[RATIO_W-1:0];

    result.rms_value      = calib ? '0 : level;
    result.ratio_value    = calib ? ratio_new : gain_ratio;
    result.is_calibration = calib;

    status.busy = (state != ENG_IDLE);
    status.done = (state == ENG_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ENG_IDLE;
      gain_ratio <= RATIO_ONE;
    end else begin
      state <= state_next;
      if (state == ENG_DONE && out_free && calib) begin
        gain_ratio <= ratio_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ENG_IDLE: begin
        if (req.go) begin
          work  <= WORK_W'(window_sum) << FRAC_SHIFT;
          rem   <= '0;
          count <= window_count;
          calib <= req.calib;
          iter  <= ITER_W'(WORK_W);
        end
      end
      ENG_MEAN: begin
        work <= {work[WORK_W-2:0], ge};
        if (last_iter) begin
          rem  <= '0;
          root <= '0;
          iter <= ITER_W'(ROOT_W);
        end else begin
          rem  <= rem_step;
          iter <= iter - ITER_W'(1);
        end
      end
      ENG_ROOT: begin
        work <= work << 2;
        rem  <= rem_step;
        root <= {root[ROOT_W-2:0], ge};
        iter <= iter - ITER_W'(1);
      end
      ENG_LOAD: begin
        // Top-align the root; measure feeds twelve more zero bits.
        work <= WORK_W'(root) << ALIGN;
        rem  <= '0;
        iter <= calib ? ITER_W'(ROOT_W) : ITER_W'(QUO_W);
      end
      ENG_DIV: begin
        work <= {work[WORK_W-2:0], ge};
        rem  <= rem_step;
        iter <= iter - ITER_W'(1);
      end
      default: begin
        work <= work;
      end
    endcase
  end

endmodule

// ----- hdl/drm_checker.sv -----
// ----------------------------------------------------------------------------
// drm_checker
// Port-level checks of the RMS meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "differential_rms_meter_assert.svh"

module drm_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input drm_pkg::drm_in_t  sample,
  input logic              result_valid,
  input logic              result_stall,
  input drm_pkg::drm_out_t result
);
  import drm_pkg::*;

  // Hold a stalled result.
  `DRM_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
                   result_valid && $stable(result), "stalled result changed")

  // Close the window: no pair is taken right after the last one.
  `DRM_ASSERT_NEXT(a_close_stalls, sample_valid && !sample_stall && sample.last_sample,
                   sample_stall, "pair taken while window closes")

  `DRM_ASSERT_IMPL(a_calib_level_zero, result_valid && result.is_calibration,
                   result.rms_value == '0, "calibration result with nonzero level")

  // A fresh result only comes out of a busy close engine.
  `DRM_ASSERT_IMPL(a_result_after_busy, $rose(result_valid),
                   $past(sample_stall), "result without window close")

endmodule

bind differential_rms_meter drm_checker u_checker (.*);

// ----- dv/differential_rms_meter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_rms_meter_checker
// Watches the sample, result and register ports of the RMS meter, keeps its
// own window sum, count and gain ratio, and compares every result transfer
// field by field against the oldest predicted window result.
// ----------------------------------------------------------------------------
module differential_rms_meter_checker #(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  input  logic                            sample_stall,
  input  drm_pkg::drm_in_t                sample,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  drm_pkg::drm_out_t               result,
  input  logic                            write_enable,
  input  logic [drm_pkg::CFG_INDEX_W-1:0] reg_index,
  input  logic [drm_pkg::CFG_DATA_W-1:0]  write_data,
  output int                              fail_count,
  output int                              pending
);
  import drm_pkg::*;

  localparam longint unsigned LEVEL_SAT = 64'hFFFF_FFFF;
  localparam logic [RATIO_W-1:0] RATIO_SAT = '1;

  logic [THRESHOLD_W-1:0] zero_level;
  logic [REFERENCE_W-1:0] cal_ref;
  logic [RATIO_W-1:0]     gain;
  longint unsigned        square_acc;
  int unsigned            pairs_held;
  drm_out_t               window_results[$];

  // Largest r with r*r <= v, built one bit at a time from the top.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, trial;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  task automatic fold_pair(input drm_in_t pair);
    longint unsigned diff, root, lvl, divisor;
    drm_out_t res;
    diff = (pair.sample_pos >= pair.sample_neg) ? 64'(pair.sample_pos) - 64'(pair.sample_neg)
                                                : 64'(pair.sample_neg) - 64'(pair.sample_pos);
    // Pairs beyond a full window are dropped, the close still happens.
    if (pairs_held < WINDOW_MAX) begin
      square_acc += diff * diff;
      pairs_held++;
    end
    if (pair.last_sample) begin
      root = floor_root((square_acc << FRAC_SHIFT) / pairs_held);
      res = '0;
      if (pair.command) begin
        divisor = 64'(cal_ref) << REF_SHIFT;
        if (divisor == 0 || root / divisor > RATIO_SAT) gain = RATIO_SAT;
        else gain = RATIO_W'(root / divisor);
        res.ratio_value    = gain;
        res.is_calibration = 1'b1;
      end else begin
        if (gain == 0) begin
          lvl = LEVEL_SAT;
        end else begin
          lvl = (root << LEVEL_SHIFT) / gain;
          if (lvl > LEVEL_SAT) lvl = LEVEL_SAT;
        end
        if (lvl < zero_level) lvl = 0;
        res.rms_value   = lvl[LEVEL_W-1:0];
        res.ratio_value = gain;
      end
      window_results.push_back(res);
      square_acc = 0;
      pairs_held = 0;
    end
  endtask

  task automatic check_result(input drm_out_t got);
    drm_out_t want;
    if (window_results.size() == 0) begin
      $error("result transfer with no window closed: rms_value %0h ratio_value %0h",
             got.rms_value, got.ratio_value);
      fail_count++;
    end else begin
      want = window_results.pop_front();
      if (got.rms_value !== want.rms_value) begin
        $error("rms_value: expected %0h, got %0h", want.rms_value, got.rms_value);
        fail_count++;
      end
      if (got.ratio_value !== want.ratio_value) begin
        $error("ratio_value: expected %0h, got %0h", want.ratio_value, got.ratio_value);
        fail_count++;
      end
      if (got.is_calibration !== want.is_calibration) begin
        $error("is_calibration: expected %0b, got %0b", want.is_calibration,
               got.is_calibration);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      zero_level = THRESHOLD_RESET;
      cal_ref    = REFERENCE_RESET;
      gain       = RATIO_ONE;
      square_acc = 0;
      pairs_held = 0;
      fail_count = 0;
      window_results.delete();
    end else begin
      if (write_enable) begin
        case (drm_reg_e'(reg_index))
          REG_ZERO_THRESHOLD: zero_level = write_data[THRESHOLD_W-1:0];
          REG_CAL_REFERENCE:  cal_ref    = write_data[REFERENCE_W-1:0];
          default: ;
        endcase
      end
      // Retire before predicting: a new close never completes in its own cycle.
      if (result_valid && !result_stall) check_result(result);
      if (sample_valid && !sample_stall) fold_pair(sample);
    end
    pending = window_results.size();
  end

endmodule

// ----- dv/tb_differential_rms_meter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_differential_rms_meter
// Drives sample pair windows into the RMS meter with bursty input and a
// shifting output stall pattern, reprograms the threshold and reference
// between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_differential_rms_meter;
  import drm_pkg::*;

  localparam int WINDOW        = 1024;
  localparam int SETTLE_CYCLES = 160;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int PHASES        = 6;
  localparam int PHASE_PAIRS   = 55;

  localparam logic CMD_MEASURE   = 1'b0;
  localparam logic CMD_CALIBRATE = 1'b1;

  typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  drm_in_t                sample = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  drm_out_t               result;
  logic                   write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0] reg_index = '0;
  logic [CFG_DATA_W-1:0]  write_data = '0;

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int          burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          stall_hold = 0;

  differential_rms_meter #(
    .SAMPLE_BITS (SAMPLE_W),
    .WINDOW_MAX  (WINDOW)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  differential_rms_meter_checker #(
    .WINDOW_MAX (WINDOW)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("differential_rms_meter: mismatch");
      $finish;
    end
  end

  // Receiver stall: switch to a randomly chosen pattern whenever the hold counter runs out.
  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_hold <= $urandom_range(20, 300);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    case (stall_mode)
      STALL_NONE:     result_stall <= 1'b0;
      STALL_COIN:     result_stall <= ($urandom_range(0, 1) == 1);
      STALL_PERIODIC: result_stall <= ((cycle_count % 5) < 2);
      default:        result_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  task automatic send_pair(input logic cmd, input logic [SAMPLE_W-1:0] pos,
                           input logic [SAMPLE_W-1:0] neg, input logic last);
    drm_in_t item;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 3);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    item.command     = cmd;
    item.sample_pos  = pos;
    item.sample_neg  = neg;
    item.last_sample = last;
    sample       <= item;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
  endtask

  // Hold off until every window result has come back and the engine is quiet.
  task automatic drain;
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] threshold,
                            input logic [CFG_DATA_W-1:0] reference);
    write_enable <= 1'b1;
    reg_index    <= REG_ZERO_THRESHOLD;
    write_data   <= threshold;
    @(posedge clk);
    reg_index    <= REG_CAL_REFERENCE;
    write_data   <= reference;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic pick_samples(output logic [SAMPLE_W-1:0] pos,
                              output logic [SAMPLE_W-1:0] neg);
    int spread;
    neg = SAMPLE_W'($urandom_range(0, 4095));
    case ($urandom_range(0, 9))
      5, 6: begin
        // small differences keep levels near the zero threshold
        spread = $urandom_range(0, 6);
        pos = SAMPLE_W'((neg > 4095 - spread) ? neg - spread : neg + spread);
      end
      7: begin
        pos = $urandom_range(0, 1) ? '1 : '0;
        neg = $urandom_range(0, 1) ? '1 : '0;
      end
      8: pos = neg;
      default: pos = SAMPLE_W'($urandom_range(0, 4095));
    endcase
  endtask

  task automatic pick_regs;
    logic [CFG_DATA_W-1:0] threshold, reference;
    case ($urandom_range(0, 3))
      0: threshold = '0;
      1: threshold = '1;
      2: threshold = THRESHOLD_RESET;
      default: threshold = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
    endcase
    case ($urandom_range(0, 5))
      0: reference = '0;
      1: reference = 16'd1;
      2: reference = 16'd255;
      default: reference = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
    endcase
    write_regs(threshold, reference);
  endtask

  task automatic run_windows(input int budget);
    int sent, len;
    logic close_cmd;
    logic [SAMPLE_W-1:0] pos, neg;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      close_cmd = ($urandom_range(0, 3) == 0) ? CMD_CALIBRATE : CMD_MEASURE;
      for (int k = 0; k < len; k++) begin
        pick_samples(pos, neg);
        if (k == len - 1) send_pair(close_cmd, pos, neg, 1'b1);
        else send_pair(logic'($urandom_range(0, 1)), pos, neg, 1'b0);
      end
      sent += len;
    end
  endtask

  initial begin
    int len;
    logic [SAMPLE_W-1:0] pos, neg;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: full swing both ways, no difference, a short window.
    send_pair(CMD_MEASURE,   4095,    0, 1'b1);
    send_pair(CMD_MEASURE,      0, 4095, 1'b1);
    send_pair(CMD_MEASURE,   2048, 2048, 1'b1);
    send_pair(CMD_CALIBRATE,  100,    0, 1'b0);
    send_pair(CMD_MEASURE,      0,  100, 1'b0);
    send_pair(CMD_MEASURE,   4095, 4095, 1'b1);
    send_pair(CMD_CALIBRATE, 4095,    0, 1'b1);
    send_pair(CMD_MEASURE,      1,    0, 1'b1);
    drain();

    // Ratio of one, then a level over the 32-bit range.
    write_regs(THRESHOLD_RESET, 16'd255);
    send_pair(CMD_CALIBRATE,    1,    0, 1'b1);
    send_pair(CMD_MEASURE,   4095,    0, 1'b1);
    send_pair(CMD_MEASURE,      0,    1, 1'b1);
    drain();

    // Zero reference saturates the ratio; top threshold zeroes small levels.
    write_regs(16'hFFFF, 16'h0000);
    send_pair(CMD_CALIBRATE,    7,    3, 1'b1);
    send_pair(CMD_MEASURE,   4095,    0, 1'b1);
    send_pair(CMD_MEASURE,      3,    0, 1'b1);
    drain();

    // Zero ratio saturates the level; upper data bits of the reference drop.
    write_regs(16'h0000, 16'hFF01);
    send_pair(CMD_CALIBRATE,    0,    0, 1'b1);
    send_pair(CMD_MEASURE,      5,    9, 1'b1);
    send_pair(CMD_CALIBRATE,    1,    2, 1'b0);
    send_pair(CMD_MEASURE,      2,    1, 1'b1);
    send_pair(CMD_CALIBRATE, 4095,    0, 1'b1);
    send_pair(CMD_MEASURE,      0,    0, 1'b1);
    drain();

    // Overfull window: pairs past the limit must not count.
    write_regs(THRESHOLD_RESET, 16'd1);
    len = WINDOW + $urandom_range(1, 16);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 3) == 0) pick_samples(pos, neg);
      else begin
        pos = '1;
        neg = '0;
      end
      send_pair(CMD_MEASURE, pos, neg, k == len - 1);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      pick_regs();
      run_windows(PHASE_PAIRS);
      drain();
    end

    if (fail_count == 0) begin
      $display("differential_rms_meter: match");
    end else begin
      $display("differential_rms_meter: mismatch");
    end
    $finish;
  end

endmodule
